### rtl/tfu_pkg.sv
// Types, codes and layout table for the texel format unpacker.
// No dependencies; used by every other source file.
package tfu_pkg;

  localparam int unsigned RawWidth  = 64;
  localparam int unsigned ChanWidth = 32;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned RepWidth  = 64;

  localparam logic [31:0] ONE_F32        = 32'h3F80_0000;
  localparam logic [7:0]  EXP_RATIO_BASE = 8'd126;
  localparam logic [7:0]  EXP_SMALL_BASE = 8'd112;
  localparam logic [7:0]  SMALL_BIAS_ADJ = 8'd112;

  localparam logic [4:0] FMT_RESET   = 5'd7;
  localparam logic [4:0] FMT_RGB10A2 = 5'd3;
  localparam logic [4:0] FMT_R8      = 5'd4;
  localparam logic [4:0] FMT_RGBA32  = 5'd15;
  localparam logic [4:0] FMT_R32     = 5'd12;
  localparam logic [4:0] FMT_R16F    = 5'd16;
  localparam logic [4:0] FMT_RGBA16F = 5'd19;
  localparam logic [4:0] FMT_R11G11B10F = 5'd20;
  localparam logic [4:0] FMT_R32F    = 5'd21;
  localparam logic [4:0] FMT_RGBA32F = 5'd24;

  localparam logic [1:0] MODE_UNORM = 2'd0;
  localparam logic [1:0] MODE_SNORM = 2'd1;
  localparam logic [1:0] MODE_SINT  = 2'd2;
  localparam logic [1:0] MODE_UINT  = 2'd3;

  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_NUMBER_MODE  = 2'd1;

  typedef enum logic [2:0] {
    OP_ZERO,
    OP_RATIO,
    OP_SNORM,
    OP_SEXT,
    OP_RAW,
    OP_SMALL,
    OP_ONE
  } lane_op_t;

  typedef struct packed {
    lane_op_t    op;
    logic [5:0]  width;
    logic [31:0] bits;
  } lane_in_t;

  typedef struct packed {
    logic [6:0] off;
    logic [5:0] w;
  } layout_t;

  function automatic layout_t lane_layout(logic [4:0] fmt, logic [1:0] lane);
    logic [5:0] w [4];
    logic [5:0] cw;
    logic [2:0] cnt;
    logic [6:0] off;
    layout_t    res;
    for (int i = 0; i < 4; i++) w[i] = 6'd0;
    cw  = 6'd0;
    cnt = 3'd0;
    case (fmt) inside
      5'd0: begin
        w[0] = 6'd4; w[1] = 6'd4; w[2] = 6'd4; w[3] = 6'd4;
      end
      5'd1: begin
        w[0] = 6'd5; w[1] = 6'd5; w[2] = 6'd5; w[3] = 6'd1;
      end
      5'd2: begin
        w[0] = 6'd5; w[1] = 6'd6; w[2] = 6'd5;
      end
      FMT_RGB10A2: begin
        w[0] = 6'd10; w[1] = 6'd10; w[2] = 6'd10; w[3] = 6'd2;
      end
      [FMT_R8:FMT_RGBA32]: begin
        cw  = (fmt < 5'd8) ? 6'd8 : (fmt < FMT_R32) ? 6'd16 : 6'd32;
        cnt = {1'b0, fmt[1:0]} + 3'd1;
      end
      [FMT_R16F:FMT_RGBA16F]: begin
        cw  = 6'd16;
        cnt = {1'b0, fmt[1:0]} + 3'd1;
      end
      [FMT_R32F:FMT_RGBA32F]: begin
        cw  = 6'd32;
        cnt = 3'(fmt - FMT_R11G11B10F);
      end
      default: cw = 6'd0;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cnt) w[i] = cw;
    end
    off = 7'd0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < lane) off = off + {1'b0, w[i]};
    end
    res.off = off;
    res.w   = w[lane];
    return res;
  endfunction

endpackage

### rtl/tfu_lane.sv
// One conversion lane: turns a channel field into a float32 or integer word.
// Two register stages; depends on tfu_pkg.
module tfu_lane (
  input  logic              clk,
  input  tfu_pkg::lane_in_t lane_in,
  output logic [31:0]       result
);

  logic        s1_norm, s1_norm_next;
  logic        s1_small, s1_small_next;
  logic [31:0] s1_value, s1_value_next;
  logic [tfu_pkg::RepWidth-1:0] s1_rep, s1_rep_next;

  function automatic logic [tfu_pkg::RepWidth-1:0] rep_fill(logic [15:0] v, logic [4:0] m);
    logic [tfu_pkg::RepWidth-1:0] r;
    int j;
    r = '0;
    for (int k = 1; k <= 16; k++) begin
      if (m == 5'(k)) begin
        j = k - 1;
        for (int i = 0; i < tfu_pkg::RepWidth; i++) begin
          r[tfu_pkg::RepWidth-1-i] = v[j];
          j = (j == 0) ? k - 1 : j - 1;
        end
      end
    end
    return r;
  endfunction

  logic [16:0] all_ones;
  logic [16:0] mag;
  logic [16:0] den;
  logic        neg;
  logic [31:0] sb32;
  logic [4:0]  s_exp;
  logic [9:0]  s_man;

  always_comb begin
    s1_norm_next  = 1'b0;
    s1_small_next = 1'b0;
    s1_value_next = '0;
    s1_rep_next   = '0;
    all_ones = (17'd1 << lane_in.width) - 17'd1;
    neg  = lane_in.bits[5'(lane_in.width - 6'd1)];
    den  = (17'd1 << (lane_in.width - 6'd1)) - 17'd1;
    mag  = neg ? (17'd1 << lane_in.width) - {1'b0, lane_in.bits[15:0]}
               : {1'b0, lane_in.bits[15:0]};
    if (mag > den) mag = den;
    sb32  = 32'd1 << (lane_in.width - 6'd1);
    s_exp = lane_in.bits[14:10];
    s_man = lane_in.bits[9:0];
    case (lane_in.op)
      tfu_pkg::OP_RATIO: begin
        if (lane_in.bits[15:0] == 16'd0) begin
          s1_value_next = '0;
        end else if ({1'b0, lane_in.bits[15:0]} == all_ones) begin
          s1_value_next = tfu_pkg::ONE_F32;
        end else begin
          s1_norm_next = 1'b1;
          s1_rep_next  = rep_fill(lane_in.bits[15:0], lane_in.width[4:0]);
        end
      end
      tfu_pkg::OP_SNORM: begin
        if (mag == 17'd0) begin
          s1_value_next = '0;
        end else if (mag == den) begin
          s1_value_next = {neg, tfu_pkg::ONE_F32[30:0]};
        end else begin
          s1_norm_next  = 1'b1;
          s1_value_next = {neg, 31'd0};
          s1_rep_next   = rep_fill(mag[15:0], 5'(lane_in.width - 6'd1));
        end
      end
      tfu_pkg::OP_SEXT: s1_value_next = (lane_in.bits ^ sb32) - sb32;
      tfu_pkg::OP_RAW:  s1_value_next = lane_in.bits;
      tfu_pkg::OP_ONE:  s1_value_next = tfu_pkg::ONE_F32;
      tfu_pkg::OP_SMALL: begin
        if (s_exp == 5'd31) begin
          s1_value_next = {lane_in.bits[15], 8'hFF, s_man, 13'd0};
        end else if (s_exp != 5'd0) begin
          s1_value_next = {lane_in.bits[15], {3'd0, s_exp} + tfu_pkg::SMALL_BIAS_ADJ,
                           s_man, 13'd0};
        end else if (s_man == 10'd0) begin
          s1_value_next = {lane_in.bits[15], 31'd0};
        end else begin
          s1_norm_next  = 1'b1;
          s1_small_next = 1'b1;
          s1_value_next = {lane_in.bits[15], 31'd0};
          s1_rep_next   = {s_man, 54'd0};
        end
      end
      default: s1_value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    s1_norm  <= s1_norm_next;
    s1_small <= s1_small_next;
    s1_value <= s1_value_next;
    s1_rep   <= s1_rep_next;
  end

  logic [3:0]  lz;
  logic        found;
  logic [tfu_pkg::RepWidth-1:0] shifted;
  logic [23:0] rounded;
  logic [7:0]  expo;
  logic [31:0] result_next;

  always_comb begin
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (s1_rep[48+i] && !found) begin
        lz    = 4'(15 - i);
        found = 1'b1;
      end
    end
    shifted = s1_rep << lz;
    rounded = {1'b0, shifted[62:40]} + {23'd0, shifted[39]};
    expo    = (s1_small ? tfu_pkg::EXP_SMALL_BASE : tfu_pkg::EXP_RATIO_BASE)
              - {4'd0, lz} + {7'd0, rounded[23]};
    result_next = s1_norm ? {s1_value[31], expo, rounded[22:0]} : s1_value;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### rtl/texel_format_unpacker.sv
// Texel format unpacker: four lanes convert one 128-bit texel per clock.
// start passes through v1 and v2 to done; throughput one item per cycle, busy never rises.
// Each lane has two register stages and the merge stage adds the output register.
// Synchronous reset clears the pipeline valids and sets format 7, mode 0.
// done marks each result for one cycle; the receiver cannot stall.
module texel_format_unpacker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] raw_low,
  input  logic [63:0] raw_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [31:0] red_value,
  output logic [31:0] green_value,
  output logic [31:0] blue_value,
  output logic [31:0] alpha_value,
  output logic        unsupported
);

  logic [4:0] pixel_format;
  logic [1:0] number_mode;
  logic       v1, v2;
  logic       bad0, bad1, bad2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= tfu_pkg::FMT_RESET;
      number_mode  <= tfu_pkg::MODE_UNORM;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tfu_pkg::CFG_PIXEL_FORMAT) pixel_format <= cfg_data;
      else if (cfg_index == tfu_pkg::CFG_NUMBER_MODE) number_mode <= cfg_data[1:0];
    end
  end

  logic [127:0]      texel;
  tfu_pkg::lane_in_t lane_in [tfu_pkg::NumLanes];
  logic [31:0]       lane_out [tfu_pkg::NumLanes];

  assign texel = {raw_high, raw_low};

  always_comb begin
    tfu_pkg::layout_t lay;
    logic [127:0]     sh;
    logic [31:0]      mask;
    bad0 = (pixel_format <= tfu_pkg::FMT_RGB10A2 && number_mode == tfu_pkg::MODE_SNORM)
        || (pixel_format >= tfu_pkg::FMT_R32 && pixel_format <= tfu_pkg::FMT_RGBA32
            && number_mode <= tfu_pkg::MODE_SNORM)
        || (pixel_format > tfu_pkg::FMT_RGBA32F);
    for (int i = 0; i < tfu_pkg::NumLanes; i++) begin
      lay  = tfu_pkg::lane_layout(pixel_format, 2'(i));
      sh   = texel >> lay.off;
      mask = (32'd1 << lay.w) - 32'd1;
      lane_in[i].width = lay.w;
      lane_in[i].bits  = sh[31:0] & mask;
      lane_in[i].op    = tfu_pkg::OP_ZERO;
      if (pixel_format == tfu_pkg::FMT_R11G11B10F) begin
        case (i)
          0: begin
            lane_in[i].op   = tfu_pkg::OP_SMALL;
            lane_in[i].bits = {16'd0, 1'b0, texel[31:21], 4'd0};
          end
          1: begin
            lane_in[i].op   = tfu_pkg::OP_SMALL;
            lane_in[i].bits = {16'd0, 1'b0, texel[20:10], 4'd0};
          end
          2: begin
            lane_in[i].op   = tfu_pkg::OP_SMALL;
            lane_in[i].bits = {16'd0, 1'b0, texel[9:0], 5'd0};
          end
          default: lane_in[i].op = tfu_pkg::OP_ONE;
        endcase
      end else if (lay.w != 6'd0) begin
        if (pixel_format >= tfu_pkg::FMT_R32F) begin
          lane_in[i].op = tfu_pkg::OP_RAW;
        end else if (pixel_format >= tfu_pkg::FMT_R16F) begin
          lane_in[i].op = tfu_pkg::OP_SMALL;
        end else begin
          case (number_mode)
            tfu_pkg::MODE_UNORM: lane_in[i].op = tfu_pkg::OP_RATIO;
            tfu_pkg::MODE_SNORM: lane_in[i].op = tfu_pkg::OP_SNORM;
            tfu_pkg::MODE_SINT:  lane_in[i].op = tfu_pkg::OP_SEXT;
            default:             lane_in[i].op = tfu_pkg::OP_RAW;
          endcase
        end
      end
    end
  end

  for (genvar g = 0; g < tfu_pkg::NumLanes; g++) begin : g_lane
    tfu_lane u_lane (
      .clk     (clk),
      .lane_in (lane_in[g]),
      .result  (lane_out[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    bad1        <= bad0;
    bad2        <= bad1;
    red_value   <= bad2 ? 32'd0 : lane_out[0];
    green_value <= bad2 ? 32'd0 : lane_out[1];
    blue_value  <= bad2 ? 32'd0 : lane_out[2];
    alpha_value <= bad2 ? 32'd0 : lane_out[3];
    unsupported <= bad2;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)) |-> (done == $past(start, 3)))
    else $error("result strobe out of step with accepted items");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && unsupported) |-> (red_value == 32'd0 && green_value == 32'd0
                               && blue_value == 32'd0 && alpha_value == 32'd0))
    else $error("unsupported item with non-zero channels");
  a_reset_cfg: assert property (@(posedge clk)
    rst |=> (pixel_format == tfu_pkg::FMT_RESET && number_mode == tfu_pkg::MODE_UNORM))
    else $error("configuration not at reset value");
`endif

endmodule

### verif/tfu_checker.sv
// Checker for texel_format_unpacker: tracks the register writes, predicts each result and
// compares it with the block's output. Depends on tfu_pkg for the register and mode codes.
`timescale 1ns / 1ps
module tfu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] raw_low,
  input  logic [63:0] raw_high,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        done,
  input  logic [31:0] red_value,
  input  logic [31:0] green_value,
  input  logic [31:0] blue_value,
  input  logic [31:0] alpha_value,
  input  logic        unsupported,
  output int          fail_count,
  output int          texels_in_flight
);
  import tfu_pkg::*;

  typedef struct {
    logic [31:0] chan [4];
    logic        bad;
  } texel_t;

  logic [4:0] cur_format;
  logic [1:0] cur_mode;
  texel_t     expected_texels [$];

  function automatic logic [31:0] field_at(logic [127:0] raw, int off, int w);
    logic [127:0] s;
    s = raw >> off;
    return (w >= 32) ? s[31:0] : (s[31:0] & ((32'd1 << w) - 32'd1));
  endfunction

  function automatic logic [31:0] ratio_f32(logic [31:0] num, logic [31:0] den);
    logic [63:0] q, rem, n;
    int s;
    q = 0; rem = 0;
    if (num == 0) return 32'd0;
    if (num >= den) return ONE_F32;
    for (s = 23; s <= 40; s++) begin
      n = {32'd0, num} << s;
      q = n / den;
      rem = n % den;
      if (q >= (64'd1 << 23)) break;
    end
    if (2 * rem > den || (2 * rem == den && q[0])) q++;
    if (q >= (64'd1 << 24)) begin
      q = q >> 1;
      s--;
    end
    return (32'(150 - s) << 23) | (q[31:0] & 32'h7F_FFFF);
  endfunction

  function automatic logic [31:0] snorm_f32(logic [31:0] v, int n);
    logic [31:0] sb, den, mag;
    logic neg;
    sb = 32'd1 << (n - 1);
    den = sb - 1;
    neg = (v & sb) != 0;
    mag = neg ? ((sb << 1) - v) : v;
    if (mag > den) mag = den;
    return ratio_f32(mag, den) | ((neg && mag != 0) ? 32'h8000_0000 : 32'd0);
  endfunction

  function automatic logic [31:0] sign_extend(logic [31:0] v, int n);
    logic [31:0] sb;
    if (n >= 32) return v;
    sb = 32'd1 << (n - 1);
    return (v ^ sb) - sb;
  endfunction

  function automatic logic [31:0] minifloat_f32(logic sgn, logic [31:0] e, logic [31:0] m,
                                                int mbits);
    logic [31:0] s;
    int p;
    s = sgn ? 32'h8000_0000 : 32'd0;
    if (e == 31) return s | 32'h7F80_0000 | (m << (23 - mbits));
    if (e != 0) return s | ((e + 112) << 23) | (m << (23 - mbits));
    if (m == 0) return s;
    p = 0;
    while ((m >> (p + 1)) != 0) p++;
    return s | (32'(113 + p - mbits) << 23) | ((m << (23 - p)) & 32'h7F_FFFF);
  endfunction

  function automatic texel_t unpack_texel(logic [4:0] fmt, logic [1:0] mode,
                                          logic [127:0] raw);
    texel_t t;
    int w [4];
    int cw, cnt, off;
    logic [31:0] v, h, r, g, b;
    t.bad = 1'b0;
    for (int i = 0; i < 4; i++) begin
      t.chan[i] = 32'd0;
      w[i] = 0;
    end
    if (fmt <= 15) begin
      case (fmt)
        5'd0: w = '{4, 4, 4, 4};
        5'd1: w = '{5, 5, 5, 1};
        5'd2: w = '{5, 6, 5, 0};
        5'd3: w = '{10, 10, 10, 2};
        default: begin
          cw = (fmt <= 7) ? 8 : (fmt <= 11) ? 16 : 32;
          cnt = (fmt - 4) % 4 + 1;
          for (int i = 0; i < cnt; i++) w[i] = cw;
        end
      endcase
      t.bad = (fmt <= 3) ? (mode == MODE_SNORM)
                         : (fmt >= FMT_R32 && (mode == MODE_UNORM || mode == MODE_SNORM));
      if (!t.bad) begin
        off = 0;
        for (int i = 0; i < 4; i++) begin
          if (w[i] != 0) begin
            v = field_at(raw, off, w[i]);
            case (mode)
              MODE_UNORM: t.chan[i] = ratio_f32(v, (32'd1 << w[i]) - 32'd1);
              MODE_SNORM: t.chan[i] = snorm_f32(v, w[i]);
              MODE_SINT:  t.chan[i] = sign_extend(v, w[i]);
              default:    t.chan[i] = v;
            endcase
            off += w[i];
          end
        end
      end
    end else if (fmt <= FMT_RGBA16F) begin
      for (int i = 0; i < fmt - 15; i++) begin
        h = field_at(raw, 16 * i, 16);
        t.chan[i] = minifloat_f32(h[15], (h >> 10) & 32'h1F, h & 32'h3FF, 10);
      end
    end else if (fmt == FMT_R11G11B10F) begin
      b = field_at(raw, 0, 10);
      g = field_at(raw, 10, 11);
      r = field_at(raw, 21, 11);
      t.chan[0] = minifloat_f32(1'b0, r >> 6, r & 32'h3F, 6);
      t.chan[1] = minifloat_f32(1'b0, g >> 6, g & 32'h3F, 6);
      t.chan[2] = minifloat_f32(1'b0, b >> 5, b & 32'h1F, 5);
      t.chan[3] = ONE_F32;
    end else if (fmt <= FMT_RGBA32F) begin
      for (int i = 0; i < fmt - 20; i++) t.chan[i] = field_at(raw, 32 * i, 32);
    end else begin
      t.bad = 1'b1;
    end
    if (t.bad) for (int i = 0; i < 4; i++) t.chan[i] = 32'd0;
    return t;
  endfunction

  function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    texel_t e;
    if (rst) begin
      cur_format <= FMT_RESET;
      cur_mode <= MODE_UNORM;
      expected_texels.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PIXEL_FORMAT) cur_format <= cfg_data;
        else if (cfg_index == CFG_NUMBER_MODE) cur_mode <= cfg_data[1:0];
      end
      if (start && !busy)
        expected_texels.push_back(unpack_texel(cur_format, cur_mode, {raw_high, raw_low}));
      if (done) begin
        if (expected_texels.size() == 0) begin
          $error("result with no item outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_texels.pop_front();
          fail_count <= fail_count + check_field("red_value", e.chan[0], red_value)
                      + check_field("green_value", e.chan[1], green_value)
                      + check_field("blue_value", e.chan[2], blue_value)
                      + check_field("alpha_value", e.chan[3], alpha_value)
                      + check_field("unsupported", {31'd0, e.bad}, {31'd0, unsupported});
        end
      end
    end
    texels_in_flight = expected_texels.size();
  end
endmodule

### verif/tb.sv
// Testbench top for texel_format_unpacker: drives texels in random bursts across every
// format and number mode, and gives the verdict. Depends on tfu_pkg and tfu_checker.
`timescale 1ns / 1ps
module tb;
  import tfu_pkg::*;

  logic        clk, rst, start, busy, cfg_valid, cfg_ready, done, unsupported;
  logic [63:0] raw_low, raw_high;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;
  logic [31:0] red_value, green_value, blue_value, alpha_value;
  int          fail_count, texels_in_flight, quiet_cycles, burst_left;

  texel_format_unpacker dut (.*);
  tfu_checker chk (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    start = 1'b0;
    while (texels_in_flight != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic send_texel(logic [63:0] lo, logic [63:0] hi);
    start = 1'b1;
    raw_low = lo;
    raw_high = hi;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  function automatic logic [63:0] pick_word(int kind);
    logic [63:0] w;
    logic [7:0] corners [5];
    corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    w = {$urandom, $urandom};
    case (kind)
      0: w = 64'd0;
      1: w = '1;
      2: for (int i = 0; i < 8; i++) w[8*i +: 8] = corners[$urandom_range(0, 4)];
      3: for (int i = 0; i < 4; i++) begin
        w[16*i + 10 +: 5] = $urandom_range(0, 2) == 0 ? 5'd0 :
                            $urandom_range(0, 1) ? 5'd31 : 5'($urandom);
        if ($urandom_range(0, 2) == 0) w[16*i +: 10] = 10'd0;
      end
      4: begin
        w[21 +: 11] = {$urandom_range(0, 1) ? 5'd31 : 5'd0, 6'($urandom)};
        w[10 +: 11] = {$urandom_range(0, 1) ? 5'd31 : 5'd0, 6'($urandom)};
        w[0 +: 10] = {$urandom_range(0, 1) ? 5'd31 : 5'd0, 5'($urandom)};
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PIXEL_FORMAT;
    cfg_data = 5'd0;
    raw_low = 64'd0;
    raw_high = 64'd0;
    burst_left = 0;
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_texel(64'd0, 64'd0);
    send_texel('1, '1);
    send_texel(64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F);
    send_texel(64'h7F7F_7F7F_0101_0101, 64'h0);

    for (int pass = 0; pass < 2; pass++) begin
      for (int f = 0; f < 32; f++) begin
        for (int m = 0; m < 4; m++) begin
          drain();
          write_reg(CFG_PIXEL_FORMAT, 5'(f));
          write_reg(CFG_NUMBER_MODE, {3'($urandom), 2'(m)});
          repeat ((f <= 24) ? 6 : 4)
            send_texel(pick_word($urandom_range(0, 6)), pick_word($urandom_range(0, 6)));
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

### sim.f
rtl/tfu_pkg.sv
rtl/tfu_lane.sv
rtl/texel_format_unpacker.sv
verif/tfu_checker.sv
verif/tb.sv
